@@ hw/rtl/afcd_pkg.sv @@
package afcd_pkg;

   // framing characters
   localparam logic [7:0] START_CHAR = 8'h21;  // '!'
   localparam logic [7:0] END_CHAR   = 8'h2A;  // '*'
   localparam logic [7:0] SPLIT_CHAR = 8'h3B;  // ';'
   localparam logic [7:0] CHECK_CHAR = 8'h24;  // '$'
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] MINUS_CHAR = 8'h2D;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] TAB_CHAR   = 8'h09;
   localparam logic [7:0] CR_CHAR    = 8'h0D;
   localparam logic [7:0] ZERO_CHAR  = 8'h30;
   localparam logic [7:0] NINE_CHAR  = 8'h39;

   localparam logic [19:0] VALUE_CAP = 20'hFFFFF;

   // defaults for the top level parameters
   localparam int FRAME_BYTES_DEFAULT      = 250;
   localparam int MAX_FIELDS_DEFAULT       = 7;
   localparam int FIELD_BYTES_DEFAULT      = 21;
   localparam int CHECK_TEXT_BYTES_DEFAULT = 7;

   // result kinds
   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [2:0] FIELD_COUNT_CAP = 3'd7;

   // checksum text parser phase
   typedef enum logic [3:0] {
      PH_BLANK  = 4'b0001,
      PH_SIGN   = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

endpackage

@@ hw/rtl/afcd_channels.sv @@
interface afcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface afcd_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [7:0]         out_byte;
   logic [2:0]         field_index;
   logic [4:0]         field_position;
   logic               frame_ok;
   logic [15:0]        payload_sum;
   logic signed [20:0] received_check;
   logic [2:0]         field_count;

   modport source (output valid, output kind, output out_byte, output field_index,
                   output field_position, output frame_ok, output payload_sum,
                   output received_check, output field_count, input ready);
   modport sink (input valid, input kind, input out_byte, input field_index,
                 input field_position, input frame_ok, input payload_sum,
                 input received_check, input field_count, output ready);
endinterface

@@ hw/rtl/ascii_frame_checksum_deframer_top.sv @@
// ASCII frame deframer with additive checksum check. Takes one received byte per request,
// hunts for '!', then emits each payload character with its field index (split by ';')
// and position, sums the payload bytes, parses the decimal text after '$' and at '*'
// sends one report saying whether that value equals the sum. Every request is handled by
// the frame state registers as it is taken, so a new request is taken every clock;
// the one-entry result register only holds off requests while a result waits and the
// response side is not ready. A result is valid in the cycle after its request is taken.
module ascii_frame_checksum_deframer_top #(
   parameter int FRAME_BYTES      = afcd_pkg::FRAME_BYTES_DEFAULT,
   parameter int MAX_FIELDS       = afcd_pkg::MAX_FIELDS_DEFAULT,
   parameter int FIELD_BYTES      = afcd_pkg::FIELD_BYTES_DEFAULT,
   parameter int CHECK_TEXT_BYTES = afcd_pkg::CHECK_TEXT_BYTES_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   afcd_req_if.sink  req,
   afcd_rsp_if.source rsp
);

   localparam logic [7:0] FRAME_LAST = 8'(FRAME_BYTES - 1);
   localparam logic [2:0] FIELD_LAST = 3'(MAX_FIELDS - 1);
   localparam logic [4:0] POS_LAST   = 5'(FIELD_BYTES - 2);
   localparam logic [2:0] CHECK_LAST = 3'(CHECK_TEXT_BYTES - 1);

   // frame state
   logic                 in_frame_ff, in_frame_in;
   logic [7:0]           byte_count_ff, byte_count_in;
   logic [15:0]          running_sum_ff, running_sum_in;
   logic                 in_check_ff, in_check_in;
   logic [2:0]           check_count_ff, check_count_in;
   logic [19:0]          check_value_ff, check_value_in;
   logic                 check_neg_ff, check_neg_in;
   afcd_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]           field_number_ff, field_number_in;
   logic [4:0]           char_pos_ff, char_pos_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic                 out_load;
   logic                 kind_ff, kind_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic [2:0]           field_index_ff, field_index_in;
   logic [4:0]           field_position_ff, field_position_in;
   logic                 frame_ok_ff, frame_ok_in;
   logic [15:0]          payload_sum_ff, payload_sum_in;
   logic signed [20:0]   received_check_ff, received_check_in;
   logic [2:0]           field_count_ff, field_count_in;

   logic                 accept;
   logic [7:0]           b;
   logic                 is_digit;
   logic                 is_blank;
   logic [3:0]           digit;
   logic [23:0]          times_ten;
   logic [19:0]          next_value;
   logic [20:0]          mag_ext;
   logic [3:0]           fc_wide;

   assign req.ready = !out_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign b         = req.rx_byte;

   assign is_digit  = (b >= afcd_pkg::ZERO_CHAR) && (b <= afcd_pkg::NINE_CHAR);
   assign is_blank  = (b == afcd_pkg::SPACE_CHAR) ||
                      ((b >= afcd_pkg::TAB_CHAR) && (b <= afcd_pkg::CR_CHAR));
   assign digit     = is_digit ? 4'(b - afcd_pkg::ZERO_CHAR) : 4'd0;
   // value * 10 + digit as two shifted adds, then saturate
   assign times_ten = {1'b0, check_value_ff, 3'b000} + {3'b000, check_value_ff, 1'b0} +
                      {20'd0, digit};
   assign next_value = (times_ten > {4'd0, afcd_pkg::VALUE_CAP}) ?
                       afcd_pkg::VALUE_CAP : times_ten[19:0];
   assign mag_ext   = {1'b0, check_value_ff};
   assign fc_wide   = {1'b0, field_number_ff} + 4'd1;

   always_comb begin
      in_frame_in       = in_frame_ff;
      byte_count_in     = byte_count_ff;
      running_sum_in    = running_sum_ff;
      in_check_in       = in_check_ff;
      check_count_in    = check_count_ff;
      check_value_in    = check_value_ff;
      check_neg_in      = check_neg_ff;
      phase_in          = phase_ff;
      field_number_in   = field_number_ff;
      char_pos_in       = char_pos_ff;
      out_load          = 1'b0;
      kind_in           = afcd_pkg::KIND_CHAR;
      out_byte_in       = 8'd0;
      field_index_in    = 3'd0;
      field_position_in = 5'd0;
      frame_ok_in       = 1'b0;
      payload_sum_in    = 16'd0;
      received_check_in = 21'sd0;
      field_count_in    = 3'd0;

      if (accept) begin
         if (!in_frame_ff) begin
            if (b == afcd_pkg::START_CHAR) begin
               in_frame_in     = 1'b1;
               byte_count_in   = 8'd1;
               running_sum_in  = 16'd0;
               in_check_in     = 1'b0;
               check_count_in  = 3'd0;
               check_value_in  = 20'd0;
               check_neg_in    = 1'b0;
               phase_in        = afcd_pkg::PH_BLANK;
               field_number_in = 3'd0;
               char_pos_in     = 5'd0;
            end
         end else if (b == afcd_pkg::END_CHAR) begin
            out_load          = 1'b1;
            kind_in           = afcd_pkg::KIND_REPORT;
            // negative zero still matches a zero sum
            frame_ok_in       = in_check_ff &&
                                (check_value_ff == {4'd0, running_sum_ff}) &&
                                (!check_neg_ff || (check_value_ff == 20'd0));
            payload_sum_in    = running_sum_ff;
            received_check_in = check_neg_ff ? -$signed(mag_ext) : $signed(mag_ext);
            field_count_in    = fc_wide[3] ? afcd_pkg::FIELD_COUNT_CAP : fc_wide[2:0];
            in_frame_in       = 1'b0;
         end else if (byte_count_ff < FRAME_LAST) begin
            byte_count_in = byte_count_ff + 8'd1;
            if (in_check_ff) begin
               if (check_count_ff < CHECK_LAST) begin
                  check_count_in = check_count_ff + 3'd1;
                  unique case (phase_ff)
                     afcd_pkg::PH_BLANK: begin
                        if (is_blank) begin
                           phase_in = afcd_pkg::PH_BLANK;
                        end else if (b == afcd_pkg::PLUS_CHAR ||
                                     b == afcd_pkg::MINUS_CHAR) begin
                           check_neg_in = (b == afcd_pkg::MINUS_CHAR);
                           phase_in     = afcd_pkg::PH_SIGN;
                        end else if (is_digit) begin
                           check_value_in = {16'd0, digit};
                           phase_in       = afcd_pkg::PH_DIGITS;
                        end else begin
                           phase_in = afcd_pkg::PH_DONE;
                        end
                     end
                     afcd_pkg::PH_SIGN, afcd_pkg::PH_DIGITS: begin
                        if (is_digit) begin
                           check_value_in = next_value;
                           phase_in       = afcd_pkg::PH_DIGITS;
                        end else begin
                           phase_in = afcd_pkg::PH_DONE;
                        end
                     end
                     afcd_pkg::PH_DONE: begin
                        phase_in = afcd_pkg::PH_DONE;
                     end
                     default: begin
                        phase_in = afcd_pkg::PH_DONE;
                     end
                  endcase
               end
            end else if (b == afcd_pkg::CHECK_CHAR) begin
               in_check_in = 1'b1;
            end else begin
               running_sum_in = running_sum_ff + {8'd0, b};
               if (b == afcd_pkg::SPLIT_CHAR) begin
                  if (field_number_ff < FIELD_LAST) begin
                     field_number_in = field_number_ff + 3'd1;
                  end
                  char_pos_in = 5'd0;
               end else if (b != afcd_pkg::START_CHAR) begin
                  out_load          = 1'b1;
                  kind_in           = afcd_pkg::KIND_CHAR;
                  out_byte_in       = b;
                  field_index_in    = field_number_ff;
                  field_position_in = char_pos_ff;
                  if (char_pos_ff < POS_LAST) begin
                     char_pos_in = char_pos_ff + 5'd1;
                  end
               end
            end
         end
      end

      priority if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff     <= 1'b0;
         byte_count_ff   <= 8'd0;
         running_sum_ff  <= 16'd0;
         in_check_ff     <= 1'b0;
         check_count_ff  <= 3'd0;
         check_value_ff  <= 20'd0;
         check_neg_ff    <= 1'b0;
         phase_ff        <= afcd_pkg::PH_BLANK;
         field_number_ff <= 3'd0;
         char_pos_ff     <= 5'd0;
         out_valid_ff    <= 1'b0;
      end else begin
         in_frame_ff     <= in_frame_in;
         byte_count_ff   <= byte_count_in;
         running_sum_ff  <= running_sum_in;
         in_check_ff     <= in_check_in;
         check_count_ff  <= check_count_in;
         check_value_ff  <= check_value_in;
         check_neg_ff    <= check_neg_in;
         phase_ff        <= phase_in;
         field_number_ff <= field_number_in;
         char_pos_ff     <= char_pos_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         kind_ff           <= kind_in;
         out_byte_ff       <= out_byte_in;
         field_index_ff    <= field_index_in;
         field_position_ff <= field_position_in;
         frame_ok_ff       <= frame_ok_in;
         payload_sum_ff    <= payload_sum_in;
         received_check_ff <= received_check_in;
         field_count_ff    <= field_count_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.kind           = kind_ff;
   assign rsp.out_byte       = out_byte_ff;
   assign rsp.field_index    = field_index_ff;
   assign rsp.field_position = field_position_ff;
   assign rsp.frame_ok       = frame_ok_ff;
   assign rsp.payload_sum    = payload_sum_ff;
   assign rsp.received_check = received_check_ff;
   assign rsp.field_count    = field_count_ff;

   a_value_capped: assert property (@(posedge clock) disable iff (reset)
      check_value_ff <= afcd_pkg::VALUE_CAP)
      else $error("checksum value above cap");

   a_char_in_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && kind_ff == afcd_pkg::KIND_CHAR) |->
      (field_index_ff <= FIELD_LAST) && (field_position_ff <= POS_LAST))
      else $error("character field index or position out of range");

   a_ok_matches_sum: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && kind_ff == afcd_pkg::KIND_REPORT && frame_ok_ff) |->
      (received_check_ff[15:0] == payload_sum_ff))
      else $error("frame ok reported with mismatching checksum");

   a_hunt_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !in_frame_ff) |=> !out_valid_ff)
      else $error("result produced while hunting for frame start");

   a_cap_holds: assert property (@(posedge clock) disable iff (reset)
      (in_frame_ff && byte_count_ff >= FRAME_LAST) |=>
      (byte_count_ff == $past(byte_count_ff)))
      else $error("byte count moved past frame cap");

endmodule
